// File: rtl/core/csps_pkg.sv
// ----------------------------------------------------------------------------
// csps_pkg
// Shared codes, character constants, classes and control structs of the
// style sheet selector and property scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package csps_pkg;

    // scan modes
    localparam logic [3:0] M_NONE     = 4'd0;
    localparam logic [3:0] M_BLOCK    = 4'd1;
    localparam logic [3:0] M_CLASS    = 4'd2;
    localparam logic [3:0] M_ID       = 4'd3;
    localparam logic [3:0] M_DISCARD  = 4'd4;
    localparam logic [3:0] M_PROP     = 4'd5;
    localparam logic [3:0] M_POSTPROP = 4'd6;
    localparam logic [3:0] M_PREVAL   = 4'd7;
    localparam logic [3:0] M_VALUE    = 4'd8;
    localparam logic [3:0] M_PREURL   = 4'd9;
    localparam logic [3:0] M_URL      = 4'd10;

    // result kinds
    localparam logic [2:0] K_BLOCK = 3'd0;
    localparam logic [2:0] K_CLASS = 3'd1;
    localparam logic [2:0] K_ID    = 3'd2;
    localparam logic [2:0] K_PROP  = 3'd3;
    localparam logic [2:0] K_URLB  = 3'd4;
    localparam logic [2:0] K_URLE  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_BLOCK = 3'd0;
    localparam logic [2:0] CFG_CLASS = 3'd1;
    localparam logic [2:0] CFG_ID    = 3'd2;
    localparam logic [2:0] CFG_PROP  = 3'd3;
    localparam logic [2:0] CFG_URL   = 3'd4;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    // "url(" prefix of a value
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_LPAREN = 8'h28;

    function automatic logic f_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic f_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic logic f_namechar(input logic [7:0] c);
        return f_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h2D;
    endfunction

    function automatic logic f_identstart(input logic [7:0] c);
        return f_letter(c) || c == 8'h5F || c == 8'h2D;
    endfunction

    function automatic logic f_quote(input logic [7:0] c);
        return c == CH_SQUOTE || c == CH_DQUOTE;
    endfunction

    typedef struct packed {
        logic       latch_c;
        logic       step_done;
        logic       name_open;
        logic       name_first;
        logic       name_zero;
        logic       name_push;
        logic       value_zero;
        logic       value_push;
        logic       url_open;
        logic       url_push;
        logic       run_init;
        logic       run_value;
        logic       run_rd;
        logic       run_next;
        logic       out_load;
        logic [2:0] out_kind;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic [7:0] c;
        logic       name_empty;
        logic       name_full;
        logic       value_full;
        logic       url_full;
        logic       url_hit;
        logic       out_free;
        logic       run_last_word;
        logic       run_is_value;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/core/css_selector_property_scanner.sv
// ----------------------------------------------------------------------------
// css_selector_property_scanner
// Byte-serial style sheet scanner reporting block opens, class names,
// element ids, property name/value pairs, quoted URL bytes and URL ends.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one text byte per transaction. m_axis carries results;
//   tlast marks the final result caused by one input byte. Name and value
//   text goes out as runs of 8-byte words, name words first.
//   A byte that needs handling in one mode only is handled once; a byte
//   that ends a token is handled again in the S_AGAIN state, after any
//   word run that it starts. Each emitted run word takes a store read
//   (S_RUN_LD), then an output register load (S_RUN_PUT). The word runs
//   and the single-port stores set the rate: s_axis_tready is low while a
//   run is emitted. Results appear in the output register in the cycle after the handling.
//   Reset returns the scanner to outside any block with all counts and the
//   offset at zero and all event enables set; store contents are not reset.
//   When m_axis stalls, the output register holds and s_axis_tready drops
//   until the pending result is taken.
//   Configuration writes via i_cfg_we/i_cfg_idx/i_cfg_data are registered in the enable registers.
// ----------------------------------------------------------------------------
`default_nettype none

module css_selector_property_scanner #(
    parameter int NAME_BYTES  = 64,
    parameter int VALUE_BYTES = 64,
    parameter int URL_BYTES   = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // char_byte
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // text_word[63:0], text_bytes[67:64], start_offset[99:68],
    // end_offset[131:100], zero fill[135:132]
    output logic [135:0] m_axis_tdata,
    output logic [3:0]   m_axis_tuser,   // event_kind[2:0], text_part[3]
    output logic         m_axis_tlast,   // run_last
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_idx,
    input  wire          i_cfg_data
);

    csps_pkg::t_cmd    cmd;
    csps_pkg::t_status st;
    logic [2:0]        kind;
    logic              part;
    logic [63:0]       word;
    logic [3:0]        nbytes;
    logic [31:0]       start_off;
    logic [31:0]       end_off;

    csps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    csps_dp #(
        .NAME_BYTES  (NAME_BYTES),
        .VALUE_BYTES (VALUE_BYTES),
        .URL_BYTES   (URL_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid && s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (kind),
        .o_part      (part),
        .o_word      (word),
        .o_bytes     (nbytes),
        .o_start     (start_off),
        .o_end       (end_off),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, end_off, start_off, nbytes, word};
    assign m_axis_tuser = {part, kind};

endmodule

`default_nettype wire

// File: rtl/core/csps_dp.sv
// ----------------------------------------------------------------------------
// csps_dp
// Datapath: byte latch, stream position, name/value stores, URL counter,
// word run read-out and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csps_dp #(
    parameter int NAME_BYTES  = 64,
    parameter int VALUE_BYTES = 64,
    parameter int URL_BYTES   = 1024
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire  [7:0]        i_in_byte,
    input  csps_pkg::t_cmd    i_cmd,
    output csps_pkg::t_status o_st,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_kind,
    output logic              o_part,
    output logic [63:0]       o_word,
    output logic [3:0]        o_bytes,
    output logic [31:0]       o_start,
    output logic [31:0]       o_end,
    output logic              o_last
);

    localparam int NCW = $clog2(NAME_BYTES + 1);
    localparam int VCW = $clog2(VALUE_BYTES + 1);
    localparam int UCW = $clog2(URL_BYTES + 1);
    localparam int NW  = (NAME_BYTES + 7) / 8;
    localparam int VW  = (VALUE_BYTES + 7) / 8;
    localparam int NAW = (NW > 1) ? $clog2(NW) : 1;
    localparam int VAW = (VW > 1) ? $clog2(VW) : 1;
    localparam int RAW = (NAW > VAW) ? NAW : VAW;
    localparam int RW0 = (NCW > VCW) ? NCW : VCW;
    localparam int RW  = (RW0 > RAW + 3) ? RW0 : RAW + 3;

    logic [7:0]       r_c;
    logic [31:0]      r_pos;
    logic [31:0]      r_nbeg;
    logic [31:0]      r_ubeg;
    logic [NCW-1:0]   r_ncnt;
    logic [VCW-1:0]   r_vcnt;
    logic [UCW-1:0]   r_ucnt;
    logic             r_pre_ok;
    logic [7:0][7:0]  r_nmem [NW];
    logic [7:0][7:0]  r_vmem [VW];
    logic [63:0]      r_nrd;
    logic [63:0]      r_vrd;
    logic [RAW-1:0]   r_ridx;
    logic             r_part;

    logic             r_ov;
    logic [2:0]       r_kind;
    logic             r_opart;
    logic [63:0]      r_word;
    logic [3:0]       r_bytes;
    logic [31:0]      r_start;
    logic [31:0]      r_end;
    logic             r_last;

    logic [7:0]       c;
    logic [RW-1:0]    run_cnt;
    logic [RW-1:0]    run_rem;
    logic [3:0]       run_bytes;
    logic [63:0]      run_raw;
    logic [63:0]      run_word;
    logic             out_free;
    logic [2:0]       n_kind;
    logic [63:0]      n_word;
    logic [3:0]       n_bytes;
    logic [31:0]      n_start;
    logic [31:0]      n_end;

    assign c        = i_in_valid ? i_in_byte : r_c;
    assign out_free = !r_ov || i_out_ready;

    assign run_cnt   = r_part ? RW'(r_vcnt) : RW'(r_ncnt);
    assign run_rem   = run_cnt - (RW'(r_ridx) << 3);
    assign run_bytes = (run_rem > RW'(8)) ? 4'd8 : 4'(run_rem);
    assign run_raw   = r_part ? r_vrd : r_nrd;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            run_word[8*k +: 8] = (4'(k) < run_bytes) ? run_raw[8*k +: 8] : 8'h00;
        end
    end

    always_comb begin
        n_kind  = i_cmd.out_kind;
        n_word  = run_word;
        n_bytes = run_bytes;
        n_start = r_nbeg;
        n_end   = r_pos;
        case (i_cmd.out_kind)
            csps_pkg::K_BLOCK: begin
                n_word  = '0;
                n_bytes = 4'd0;
                n_start = r_pos;
                n_end   = r_pos + 32'd1;
            end
            csps_pkg::K_URLB: begin
                n_word  = {56'd0, c};
                n_bytes = 4'd1;
                n_start = r_ubeg;
                n_end   = r_pos + 32'd1;
            end
            csps_pkg::K_URLE: begin
                n_word  = '0;
                n_bytes = 4'd0;
                n_start = r_ubeg;
                n_end   = r_pos;
            end
            csps_pkg::K_PROP: begin
                n_end = r_pos + 32'd1;
            end
            default: begin
                n_end = r_pos;
            end
        endcase
    end

    assign o_st.c             = c;
    assign o_st.name_empty    = (r_ncnt == '0);
    assign o_st.name_full     = (r_ncnt == NCW'(NAME_BYTES));
    assign o_st.value_full    = (r_vcnt == VCW'(VALUE_BYTES));
    assign o_st.url_full      = (r_ucnt == UCW'(URL_BYTES));
    assign o_st.url_hit       = (r_vcnt == VCW'(3)) && r_pre_ok && (c == csps_pkg::CH_LPAREN);
    assign o_st.out_free      = out_free;
    assign o_st.run_last_word = (run_rem <= RW'(8));
    assign o_st.run_is_value  = r_part;

    // stores: byte writes, registered word reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.name_first) begin
            r_nmem[0][0] <= c;
        end else if (i_cmd.name_push) begin
            r_nmem[NAW'(r_ncnt >> 3)][r_ncnt[2:0]] <= c;
        end
        if (i_cmd.value_push) begin
            r_vmem[VAW'(r_vcnt >> 3)][r_vcnt[2:0]] <= c;
        end
        if (i_cmd.run_rd) begin
            r_nrd <= r_nmem[r_ridx[NAW-1:0]];
            r_vrd <= r_vmem[r_ridx[VAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c      <= '0;
            r_pos    <= '0;
            r_nbeg   <= '0;
            r_ubeg   <= '0;
            r_ncnt   <= '0;
            r_vcnt   <= '0;
            r_ucnt   <= '0;
            r_pre_ok <= 1'b0;
            r_ridx   <= '0;
            r_part   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cmd.latch_c) begin
                r_c <= i_in_byte;
            end
            if (i_cmd.step_done) begin
                r_pos <= r_pos + 32'd1;
            end
            if (i_cmd.name_open) begin
                r_nbeg <= r_pos + 32'd1;
                r_ncnt <= '0;
            end else if (i_cmd.name_first) begin
                r_nbeg <= r_pos;
                r_ncnt <= NCW'(1);
            end else if (i_cmd.name_zero) begin
                r_ncnt <= '0;
            end else if (i_cmd.name_push) begin
                r_ncnt <= r_ncnt + NCW'(1);
            end
            if (i_cmd.value_zero) begin
                r_vcnt <= '0;
            end else if (i_cmd.value_push) begin
                r_vcnt <= r_vcnt + VCW'(1);
                case (r_vcnt)
                    VCW'(0):  r_pre_ok <= (c == csps_pkg::CH_U);
                    VCW'(1):  r_pre_ok <= r_pre_ok && (c == csps_pkg::CH_R);
                    VCW'(2):  r_pre_ok <= r_pre_ok && (c == csps_pkg::CH_L);
                    default:  r_pre_ok <= r_pre_ok;
                endcase
            end
            if (i_cmd.url_open) begin
                r_ubeg <= r_pos + 32'd1;
                r_ucnt <= '0;
            end else if (i_cmd.url_push) begin
                r_ucnt <= r_ucnt + UCW'(1);
            end
            if (i_cmd.run_init) begin
                r_ridx <= '0;
                r_part <= 1'b0;
            end else if (i_cmd.run_value) begin
                r_ridx <= '0;
                r_part <= 1'b1;
            end else if (i_cmd.run_next) begin
                r_ridx <= r_ridx + RAW'(1);
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind  <= n_kind;
            r_opart <= (i_cmd.out_kind == csps_pkg::K_PROP) && r_part;
            r_word  <= n_word;
            r_bytes <= n_bytes;
            r_start <= n_start;
            r_end   <= n_end;
            r_last  <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind      = r_kind;
    assign o_part      = r_opart;
    assign o_word      = r_word;
    assign o_bytes     = r_bytes;
    assign o_start     = r_start;
    assign o_end       = r_end;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// File: rtl/core/csps_ctrl.sv
// ----------------------------------------------------------------------------
// csps_ctrl
// Controller: scan mode machine, enable registers and the sequencer that
// handles each byte, re-handles ending bytes and walks word runs.
// ----------------------------------------------------------------------------
`default_nettype none

module csps_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_cfg_we,
    input  wire  [2:0]        i_cfg_idx,
    input  wire               i_cfg_data,
    input  csps_pkg::t_status i_st,
    output csps_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_AGAIN   = 2'd1;
    localparam logic [1:0] S_RUN_LD  = 2'd2;
    localparam logic [1:0] S_RUN_PUT = 2'd3;

    logic [1:0] r_state, n_state;
    logic [3:0] r_mode, n_mode;
    logic       r_qd, n_qd;
    logic       r_again, n_again;
    logic [2:0] r_rkind, n_rkind;
    logic       r_en_block, r_en_class, r_en_id, r_en_prop, r_en_url;

    logic       accept;
    logic       exec;
    logic       h_again;
    logic       h_run;
    logic [2:0] h_rkind;
    logic       h_single;
    logic [2:0] h_skind;
    logic       h_name_open, h_name_first, h_name_zero, h_name_push;
    logic       h_value_zero, h_value_push, h_url_open, h_url_push;
    logic [7:0] c;
    logic       q_match;
    logic       cls;
    logic       run_done;
    logic       block_next;

    assign c          = i_st.c;
    assign q_match    = c == (r_qd ? csps_pkg::CH_DQUOTE : csps_pkg::CH_SQUOTE);
    assign cls        = r_mode == csps_pkg::M_CLASS;
    assign o_in_ready = (r_state == S_IDLE) && i_st.out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign exec       = accept || ((r_state == S_AGAIN) && i_st.out_free);
    // a class or id run is followed by a block open when '{' ends it
    assign block_next = (c == csps_pkg::CH_LBRACE) && r_en_block;

    // handling of the current byte in the current mode
    always_comb begin
        n_mode       = r_mode;
        n_qd         = r_qd;
        h_again      = 1'b0;
        h_run        = 1'b0;
        h_rkind      = csps_pkg::K_PROP;
        h_single     = 1'b0;
        h_skind      = csps_pkg::K_BLOCK;
        h_name_open  = 1'b0;
        h_name_first = 1'b0;
        h_name_zero  = 1'b0;
        h_name_push  = 1'b0;
        h_value_zero = 1'b0;
        h_value_push = 1'b0;
        h_url_open   = 1'b0;
        h_url_push   = 1'b0;
        case (r_mode)
            csps_pkg::M_NONE: begin
                if (c == csps_pkg::CH_LBRACE) begin
                    n_mode   = csps_pkg::M_BLOCK;
                    h_single = r_en_block;
                end else if (c == csps_pkg::CH_DOT && r_en_class) begin
                    n_mode      = csps_pkg::M_CLASS;
                    h_name_open = 1'b1;
                end else if (c == csps_pkg::CH_HASH && r_en_id) begin
                    n_mode      = csps_pkg::M_ID;
                    h_name_open = 1'b1;
                end
            end
            csps_pkg::M_CLASS, csps_pkg::M_ID: begin
                if (!csps_pkg::f_namechar(c)) begin
                    h_run   = !i_st.name_empty && (cls ? r_en_class : r_en_id);
                    h_rkind = cls ? csps_pkg::K_CLASS : csps_pkg::K_ID;
                    n_mode  = csps_pkg::M_NONE;
                    h_again = 1'b1;
                end else if (!i_st.name_full) begin
                    h_name_push = 1'b1;
                end
            end
            csps_pkg::M_BLOCK: begin
                if (c == csps_pkg::CH_RBRACE) begin
                    n_mode = csps_pkg::M_NONE;
                end else if (c == csps_pkg::CH_COLON) begin
                    n_mode      = csps_pkg::M_PREVAL;
                    h_name_zero = 1'b1;
                end else if (csps_pkg::f_quote(c)) begin
                    n_mode = csps_pkg::M_DISCARD;
                    n_qd   = c == csps_pkg::CH_DQUOTE;
                end else if (csps_pkg::f_identstart(c) && r_en_prop) begin
                    n_mode       = csps_pkg::M_PROP;
                    h_name_first = 1'b1;
                end
            end
            csps_pkg::M_DISCARD: begin
                if (q_match) begin
                    n_mode = csps_pkg::M_BLOCK;
                end
            end
            csps_pkg::M_PROP: begin
                if (!csps_pkg::f_namechar(c)) begin
                    n_mode  = csps_pkg::M_POSTPROP;
                    h_again = 1'b1;
                end else if (!i_st.name_full) begin
                    h_name_push = 1'b1;
                end
            end
            csps_pkg::M_POSTPROP: begin
                if (c == csps_pkg::CH_RBRACE) begin
                    n_mode = csps_pkg::M_NONE;
                end else if (c == csps_pkg::CH_COLON) begin
                    n_mode = csps_pkg::M_PREVAL;
                end else if (csps_pkg::f_quote(c)) begin
                    n_mode = csps_pkg::M_DISCARD;
                    n_qd   = c == csps_pkg::CH_DQUOTE;
                end
            end
            csps_pkg::M_PREVAL: begin
                if (csps_pkg::f_space(c)) begin
                    n_mode = r_mode;
                end else if (c == csps_pkg::CH_RBRACE) begin
                    n_mode = csps_pkg::M_NONE;
                end else if (c == csps_pkg::CH_SEMI) begin
                    n_mode = csps_pkg::M_BLOCK;
                end else begin
                    n_mode       = csps_pkg::M_VALUE;
                    h_value_zero = 1'b1;
                    h_again      = 1'b1;
                end
            end
            csps_pkg::M_VALUE: begin
                if (c == csps_pkg::CH_RBRACE) begin
                    n_mode = csps_pkg::M_NONE;
                end else if (c == csps_pkg::CH_SEMI) begin
                    h_run  = !i_st.name_empty && r_en_prop;
                    n_mode = csps_pkg::M_BLOCK;
                end else if (csps_pkg::f_quote(c)) begin
                    n_mode = csps_pkg::M_DISCARD;
                    n_qd   = c == csps_pkg::CH_DQUOTE;
                end else if (!i_st.value_full) begin
                    h_value_push = 1'b1;
                    if (r_en_url && i_st.url_hit) begin
                        n_mode = csps_pkg::M_PREURL;
                    end
                end
            end
            csps_pkg::M_PREURL: begin
                if (csps_pkg::f_space(c)) begin
                    n_mode = r_mode;
                end else if (c == csps_pkg::CH_RBRACE) begin
                    n_mode = csps_pkg::M_NONE;
                end else if (csps_pkg::f_quote(c)) begin
                    n_mode     = csps_pkg::M_URL;
                    n_qd       = c == csps_pkg::CH_DQUOTE;
                    h_url_open = 1'b1;
                end else begin
                    n_mode  = csps_pkg::M_BLOCK;
                    h_again = 1'b1;
                end
            end
            csps_pkg::M_URL: begin
                if (q_match) begin
                    h_single = r_en_url;
                    h_skind  = csps_pkg::K_URLE;
                    n_mode   = csps_pkg::M_BLOCK;
                end else if (!i_st.url_full) begin
                    h_url_push = 1'b1;
                    h_single   = r_en_url;
                    h_skind    = csps_pkg::K_URLB;
                end
            end
            default: begin
                n_mode = csps_pkg::M_NONE;
            end
        endcase
    end

    assign run_done = (r_state == S_RUN_PUT) && i_st.out_free && i_st.run_last_word &&
                      !((r_rkind == csps_pkg::K_PROP) && !i_st.run_is_value);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_again = r_again;
        n_rkind = r_rkind;
        o_cmd   = '0;
        o_cmd.latch_c    = accept;
        o_cmd.name_open  = exec && h_name_open;
        o_cmd.name_first = exec && h_name_first;
        o_cmd.name_zero  = exec && h_name_zero;
        o_cmd.name_push  = exec && h_name_push;
        o_cmd.value_zero = exec && h_value_zero;
        o_cmd.value_push = exec && h_value_push;
        o_cmd.url_open   = exec && h_url_open;
        o_cmd.url_push   = exec && h_url_push;
        o_cmd.out_kind   = h_skind;
        case (r_state)
            S_IDLE, S_AGAIN: begin
                if (exec) begin
                    o_cmd.out_load = h_single;
                    o_cmd.out_last = 1'b1;
                    if (h_run) begin
                        o_cmd.run_init = 1'b1;
                        n_again        = h_again;
                        n_rkind        = h_rkind;
                        n_state        = S_RUN_LD;
                    end else if (h_again) begin
                        n_state = S_AGAIN;
                    end else begin
                        o_cmd.step_done = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            S_RUN_LD: begin
                o_cmd.run_rd = 1'b1;
                n_state      = S_RUN_PUT;
            end
            S_RUN_PUT: begin
                o_cmd.out_kind = r_rkind;
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.run_next = 1'b1;
                    if (r_rkind == csps_pkg::K_PROP) begin
                        o_cmd.out_last = i_st.run_last_word && i_st.run_is_value;
                    end else begin
                        o_cmd.out_last = i_st.run_last_word && !block_next;
                    end
                    if (!i_st.run_last_word) begin
                        n_state = S_RUN_LD;
                    end else if (!run_done) begin
                        // name words sent, move on to the value words
                        o_cmd.run_next  = 1'b0;
                        o_cmd.run_value = 1'b1;
                        n_state         = S_RUN_LD;
                    end else if (r_again) begin
                        n_state = S_AGAIN;
                    end else begin
                        o_cmd.step_done = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= csps_pkg::M_NONE;
            r_qd       <= 1'b0;
            r_again    <= 1'b0;
            r_rkind    <= csps_pkg::K_PROP;
            r_en_block <= 1'b1;
            r_en_class <= 1'b1;
            r_en_id    <= 1'b1;
            r_en_prop  <= 1'b1;
            r_en_url   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_again <= n_again;
            r_rkind <= n_rkind;
            if (exec) begin
                r_mode <= n_mode;
                r_qd   <= n_qd;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csps_pkg::CFG_BLOCK: r_en_block <= i_cfg_data;
                    csps_pkg::CFG_CLASS: r_en_class <= i_cfg_data;
                    csps_pkg::CFG_ID:    r_en_id    <= i_cfg_data;
                    csps_pkg::CFG_PROP:  r_en_prop  <= i_cfg_data;
                    csps_pkg::CFG_URL:   r_en_url   <= i_cfg_data;
                    default:             r_en_url   <= r_en_url;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
